### hw/rtl/rie_pkg.sv
// Package: shared types, opcodes and constants of the integer execute unit.
`timescale 1ns / 1ps
package rie_pkg;

  localparam int unsigned MemBytesDefault = 65536;

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpBlez    = 6'h06;
  localparam logic [5:0] OpBgtz    = 6'h07;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpSlti    = 6'h0a;
  localparam logic [5:0] OpSltiu   = 6'h0b;
  localparam logic [5:0] OpAndi    = 6'h0c;
  localparam logic [5:0] OpOri     = 6'h0d;
  localparam logic [5:0] OpXori    = 6'h0e;
  localparam logic [5:0] OpLui     = 6'h0f;
  localparam logic [5:0] OpLb      = 6'h20;
  localparam logic [5:0] OpLh      = 6'h21;
  localparam logic [5:0] OpLwl     = 6'h22;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpLbu     = 6'h24;
  localparam logic [5:0] OpLhu     = 6'h25;
  localparam logic [5:0] OpLwr     = 6'h26;
  localparam logic [5:0] OpSb      = 6'h28;
  localparam logic [5:0] OpSh      = 6'h29;
  localparam logic [5:0] OpSwl     = 6'h2a;
  localparam logic [5:0] OpSw      = 6'h2b;
  localparam logic [5:0] OpSwr     = 6'h2e;

  localparam logic [5:0] FnSll     = 6'h00;
  localparam logic [5:0] FnSrl     = 6'h02;
  localparam logic [5:0] FnSra     = 6'h03;
  localparam logic [5:0] FnSllv    = 6'h04;
  localparam logic [5:0] FnSrlv    = 6'h06;
  localparam logic [5:0] FnSrav    = 6'h07;
  localparam logic [5:0] FnJr      = 6'h08;
  localparam logic [5:0] FnJalr    = 6'h09;
  localparam logic [5:0] FnMovz    = 6'h0a;
  localparam logic [5:0] FnMovn    = 6'h0b;
  localparam logic [5:0] FnSyscall = 6'h0c;
  localparam logic [5:0] FnBreak   = 6'h0d;
  localparam logic [5:0] FnMfhi    = 6'h10;
  localparam logic [5:0] FnMthi    = 6'h11;
  localparam logic [5:0] FnMflo    = 6'h12;
  localparam logic [5:0] FnMtlo    = 6'h13;
  localparam logic [5:0] FnMult    = 6'h18;
  localparam logic [5:0] FnMultu   = 6'h19;
  localparam logic [5:0] FnDiv     = 6'h1a;
  localparam logic [5:0] FnDivu    = 6'h1b;
  localparam logic [5:0] FnAdd     = 6'h20;
  localparam logic [5:0] FnAddu    = 6'h21;
  localparam logic [5:0] FnSub     = 6'h22;
  localparam logic [5:0] FnSubu    = 6'h23;
  localparam logic [5:0] FnAnd     = 6'h24;
  localparam logic [5:0] FnOr      = 6'h25;
  localparam logic [5:0] FnXor     = 6'h26;
  localparam logic [5:0] FnNor     = 6'h27;
  localparam logic [5:0] FnSlt     = 6'h2a;
  localparam logic [5:0] FnSltu    = 6'h2b;
  localparam logic [5:0] FnTge     = 6'h30;
  localparam logic [5:0] FnTgeu    = 6'h31;
  localparam logic [5:0] FnTlt     = 6'h32;
  localparam logic [5:0] FnTltu    = 6'h33;
  localparam logic [5:0] FnTeq     = 6'h34;
  localparam logic [5:0] FnTne     = 6'h36;

  localparam logic [4:0] LinkReg = 5'd31;

  typedef enum logic [2:0] {
    ExcNone, ExcOverflow, ExcLoadAddr, ExcStoreAddr,
    ExcTrap, ExcBreak, ExcSyscall, ExcReserved
  } exc_e;

  typedef enum logic [1:0] {MdMult, MdMultu, MdDiv, MdDivu} md_op_e;

  typedef enum logic [2:0] {StClear, StIdle, StExec, StLoad, StMd, StRes} state_e;

  typedef enum logic [1:0] {MdIdle, MdRun, MdFix, MdDone} md_state_e;

  typedef struct packed {
    exc_e        exc;
    logic [31:0] bad;
    logic        redir;
    logic [31:0] target;
    logic        wbv;
    logic [4:0]  wbr;
    logic [31:0] wbval;
  } res_t;

  typedef struct packed {
    logic        start;
    md_op_e      op;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage

### hw/rtl/rie_if.sv
// Interfaces: instruction/preload input channel and result output channel.
`timescale 1ns / 1ps
interface rie_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] instr;
  logic [31:0] pc_read;
  logic [13:0] mem_index;
  logic [31:0] mem_word;
  modport source (output valid, cmd, instr, pc_read, mem_index, mem_word, input ready);
  modport sink (input valid, cmd, instr, pc_read, mem_index, mem_word, output ready);
endinterface

interface rie_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  exc_code;
  logic [31:0] bad_vaddr;
  logic        redirect;
  logic [31:0] target_pc;
  logic        wb_valid;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  modport source (output valid, exc_code, bad_vaddr, redirect, target_pc, wb_valid, wb_reg,
                  wb_value, input ready);
  modport sink (input valid, exc_code, bad_vaddr, redirect, target_pc, wb_valid, wb_reg,
                wb_value, output ready);
endinterface

### hw/rtl/rie_muldiv.sv
// Iterative multiply/divide unit: one shared adder, one bit per cycle.
`timescale 1ns / 1ps
module rie_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rie_pkg::md_req_t  req_i,
  output rie_pkg::md_rsp_t  rsp_o
);
  import rie_pkg::*;

  md_state_e   st_q, st_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] hi_q, hi_d, lo_q, lo_d, m_q, m_d;
  logic        mul_q, mul_d, neg_lo_q, neg_lo_d, neg_hi_q, neg_hi_d;

  logic        sgn, is_div, na, nb;
  logic [31:0] ma, mb;
  logic [33:0] x34, y34, s34;
  logic [63:0] prod_neg;

  assign sgn    = (req_i.op == MdMult) || (req_i.op == MdDiv);
  assign is_div = (req_i.op == MdDiv) || (req_i.op == MdDivu);
  assign na     = sgn & req_i.a[31];
  assign nb     = sgn & req_i.b[31];
  assign ma     = na ? (~req_i.a + 32'd1) : req_i.a;
  assign mb     = nb ? (~req_i.b + 32'd1) : req_i.b;

  assign x34 = mul_q ? {2'b00, hi_q} : {1'b0, hi_q, lo_q[31]};
  assign y34 = mul_q ? (lo_q[0] ? {2'b00, m_q} : 34'd0) : ~{2'b00, m_q};
  assign s34 = x34 + y34 + {33'd0, ~mul_q};
  assign prod_neg = ~{hi_q, lo_q} + 64'd1;

  always_comb begin
    st_d = st_q;
    case (st_q)
      MdIdle: begin
        if (req_i.start) begin
          st_d = (is_div && (req_i.b == 32'd0)) ? MdDone : MdRun;
        end
      end
      MdRun:   if (cnt_q == 5'd31) st_d = MdFix;
      MdFix:   st_d = MdDone;
      MdDone:  st_d = MdIdle;
      default: st_d = MdIdle;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    m_d      = m_q;
    mul_d    = mul_q;
    neg_lo_d = neg_lo_q;
    neg_hi_d = neg_hi_q;
    case (st_q)
      MdIdle: begin
        if (req_i.start) begin
          if (is_div && (req_i.b == 32'd0)) begin
            hi_d = req_i.a;
            lo_d = 32'hFFFFFFFF;
          end else begin
            hi_d     = 32'd0;
            lo_d     = ma;
            m_d      = mb;
            mul_d    = ~is_div;
            neg_lo_d = na ^ nb;
            neg_hi_d = is_div ? na : (na ^ nb);
            cnt_d    = 5'd0;
          end
        end
      end
      MdRun: begin
        cnt_d = cnt_q + 5'd1;
        if (mul_q) begin
          hi_d = s34[32:1];
          lo_d = {s34[0], lo_q[31:1]};
        end else begin
          hi_d = s34[33] ? {hi_q[30:0], lo_q[31]} : s34[31:0];
          lo_d = {lo_q[30:0], ~s34[33]};
        end
      end
      MdFix: begin
        if (mul_q) begin
          if (neg_lo_q) {hi_d, lo_d} = prod_neg;
        end else begin
          if (neg_lo_q) lo_d = ~lo_q + 32'd1;
          if (neg_hi_q) hi_d = ~hi_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= MdIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    m_q      <= m_d;
    mul_q    <= mul_d;
    neg_lo_q <= neg_lo_d;
    neg_hi_q <= neg_hi_d;
  end

  assign rsp_o.done = (st_q == MdDone);
  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;

endmodule

### hw/rtl/risc_integer_execute_unit.sv
// Top level: sequenced integer execute unit with register file, HI/LO and data memory.
`timescale 1ns / 1ps
// One item at a time. After reset a clearing pass zeroes the data memory one word per cycle,
// and no item is taken meanwhile. From acceptance to the result register, a preload goes
// straight to the result step; ALU, branch, jump, trap and store instructions pass register
// read, execute and result; loads add a step for the registered data memory read; and
// multiply/divide waits in its own step for the multiply/divide unit, whose shared adder
// retires one bit per cycle; a divide by zero skips that loop. A new item is taken once the
// result has moved to the output register, even while that result is still waiting.
module risc_integer_execute_unit #(
  parameter int unsigned MEM_BYTES = rie_pkg::MemBytesDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  rie_in_if.sink     in_i,
  rie_out_if.source  out_o
);
  import rie_pkg::*;

  localparam int unsigned Words = (MEM_BYTES + 3) / 4;
  localparam int unsigned Aw    = $clog2(Words);

  state_e      state_q, state_d;
  logic        ov_q;
  res_t        out_q, res_q, res_d, r;
  logic [31:0] instr_q, pc_q, a_q, b_q;
  logic [31:0] rf [32];
  logic [31:0] rf_vld_q;
  logic [31:0] hi_q, lo_q;
  logic [31:0] mem [Words];
  logic [31:0] mem_rdata_q;
  logic [Aw-1:0] clr_cnt_q;

  logic        in_acc, out_load;
  logic [4:0]  rs_in, rt_in;
  logic [31:0] pl_base, pl_idx32;
  logic        pl_ok;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, pc4, y, sum, diff, addr, hi_addr, w;
  logic [32:0] diff33;
  logic        ltu, lts;
  logic [1:0]  b2;
  logic        is_mem, is_store, is_load, is_md, misal, mem_fault;

  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        hi_we, lo_we;
  logic [31:0] hi_wd, lo_wd;
  logic        mem_we;
  logic [3:0]  mem_be;
  logic [Aw-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        wb_req;
  logic [4:0]  wb_r;
  logic [31:0] wb_v;
  logic [31:0] ld_mask;

  md_req_t     md_req;
  md_rsp_t     md_rsp;

  rie_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == StRes) && (!ov_q || out_o.ready);
  assign rs_in      = in_i.instr[25:21];
  assign rt_in      = in_i.instr[20:16];
  assign pl_base    = {16'd0, in_i.mem_index, 2'b11};
  assign pl_ok      = pl_base < 32'(MEM_BYTES);
  assign pl_idx32   = {18'd0, in_i.mem_index};

  assign op   = instr_q[31:26];
  assign rt   = instr_q[20:16];
  assign rd   = instr_q[15:11];
  assign sh   = instr_q[10:6];
  assign fn   = instr_q[5:0];
  assign imm  = instr_q[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign pc4  = pc_q + 32'd4;

  assign y      = (op == OpSpecial) ? b_q : simm;
  assign sum    = a_q + y;
  assign diff33 = {1'b0, a_q} - {1'b0, y};
  assign diff   = diff33[31:0];
  assign ltu    = diff33[32];
  assign lts    = (a_q[31] != y[31]) ? a_q[31] : diff33[31];

  assign addr     = sum;
  assign b2       = addr[1:0];
  assign is_mem   = (op == OpLb) || (op == OpLh) || (op == OpLwl) || (op == OpLw) ||
                    (op == OpLbu) || (op == OpLhu) || (op == OpLwr) || (op == OpSb) ||
                    (op == OpSh) || (op == OpSwl) || (op == OpSw) || (op == OpSwr);
  assign is_store = is_mem && op[3];
  assign is_load  = is_mem && !op[3];
  assign is_md    = (op == OpSpecial) && ((fn == FnMult) || (fn == FnMultu) ||
                    (fn == FnDiv) || (fn == FnDivu));

  always_comb begin
    misal   = 1'b0;
    hi_addr = addr;
    case (op)
      OpLh, OpLhu, OpSh: begin
        misal   = addr[0];
        hi_addr = {addr[31:2], addr[1], 1'b1};
      end
      OpLw, OpSw: begin
        misal   = (b2 != 2'b00);
        hi_addr = {addr[31:2], 2'b11};
      end
      OpLwr, OpSwr: hi_addr = {addr[31:2], 2'b11};
      default: ;
    endcase
  end
  assign mem_fault = misal || (hi_addr >= 32'(MEM_BYTES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_cnt_q == Aw'(Words - 1)) state_d = StIdle;
      StIdle:  if (in_acc) state_d = in_i.cmd ? StRes : StExec;
      StExec: begin
        if (is_load && !mem_fault) state_d = StLoad;
        else if (is_md)            state_d = StMd;
        else                       state_d = StRes;
      end
      StLoad:  state_d = StRes;
      StMd:    if (md_rsp.done) state_d = StRes;
      StRes:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign w = mem_rdata_q;

  always_comb begin
    res_d   = res_q;
    r       = '0;
    rf_we   = 1'b0;
    rf_wa   = rt;
    rf_wd   = '0;
    hi_we   = 1'b0;
    lo_we   = 1'b0;
    hi_wd   = a_q;
    lo_wd   = a_q;
    mem_we  = 1'b0;
    mem_be  = 4'b0000;
    mem_wa  = addr[Aw+1:2];
    mem_wd  = b_q;
    wb_req  = 1'b0;
    wb_r    = rt;
    wb_v    = '0;
    ld_mask = '0;
    md_req.start = 1'b0;
    md_req.a     = a_q;
    md_req.b     = b_q;
    case (fn)
      FnMult:  md_req.op = MdMult;
      FnMultu: md_req.op = MdMultu;
      FnDiv:   md_req.op = MdDiv;
      default: md_req.op = MdDivu;
    endcase
    case (state_q)
      StClear: begin
        mem_we = 1'b1;
        mem_be = 4'b1111;
        mem_wa = clr_cnt_q;
        mem_wd = '0;
      end
      StIdle: begin
        if (in_acc) res_d = '0;
        if (in_acc && in_i.cmd && pl_ok) begin
          mem_we = 1'b1;
          mem_be = 4'b1111;
          mem_wa = pl_idx32[Aw-1:0];
          mem_wd = in_i.mem_word;
        end
      end
      StExec: begin
        case (op)
          OpSpecial: begin
            wb_r = rd;
            case (fn)
              FnSll:  begin wb_req = 1'b1; wb_v = b_q << sh; end
              FnSrl:  begin wb_req = 1'b1; wb_v = b_q >> sh; end
              FnSra:  begin wb_req = 1'b1; wb_v = 32'($signed(b_q) >>> sh); end
              FnSllv: begin wb_req = 1'b1; wb_v = b_q << a_q[4:0]; end
              FnSrlv: begin wb_req = 1'b1; wb_v = b_q >> a_q[4:0]; end
              FnSrav: begin wb_req = 1'b1; wb_v = 32'($signed(b_q) >>> a_q[4:0]); end
              FnJr: begin
                r.redir  = 1'b1;
                r.target = a_q;
              end
              FnJalr: begin
                r.redir  = 1'b1;
                r.target = a_q;
                wb_req   = 1'b1;
                wb_v     = pc4;
              end
              FnMovz:    begin wb_req = (b_q == 32'd0); wb_v = a_q; end
              FnMovn:    begin wb_req = (b_q != 32'd0); wb_v = a_q; end
              FnSyscall: r.exc = ExcSyscall;
              FnBreak:   r.exc = ExcBreak;
              FnMfhi:    begin wb_req = 1'b1; wb_v = hi_q; end
              FnMthi:    hi_we = 1'b1;
              FnMflo:    begin wb_req = 1'b1; wb_v = lo_q; end
              FnMtlo:    lo_we = 1'b1;
              FnMult, FnMultu, FnDiv, FnDivu: md_req.start = 1'b1;
              FnAdd: begin
                if (((a_q ^ sum) & (y ^ sum)) >> 31 != 32'd0) r.exc = ExcOverflow;
                else begin wb_req = 1'b1; wb_v = sum; end
              end
              FnAddu: begin wb_req = 1'b1; wb_v = sum; end
              FnSub: begin
                if (((a_q ^ y) & (a_q ^ diff)) >> 31 != 32'd0) r.exc = ExcOverflow;
                else begin wb_req = 1'b1; wb_v = diff; end
              end
              FnSubu: begin wb_req = 1'b1; wb_v = diff; end
              FnAnd:  begin wb_req = 1'b1; wb_v = a_q & b_q; end
              FnOr:   begin wb_req = 1'b1; wb_v = a_q | b_q; end
              FnXor:  begin wb_req = 1'b1; wb_v = a_q ^ b_q; end
              FnNor:  begin wb_req = 1'b1; wb_v = ~(a_q | b_q); end
              FnSlt:  begin wb_req = 1'b1; wb_v = {31'd0, lts}; end
              FnSltu: begin wb_req = 1'b1; wb_v = {31'd0, ltu}; end
              FnTge:  if (!lts) r.exc = ExcTrap;
              FnTgeu: if (!ltu) r.exc = ExcTrap;
              FnTlt:  if (lts) r.exc = ExcTrap;
              FnTltu: if (ltu) r.exc = ExcTrap;
              FnTeq:  if (a_q == b_q) r.exc = ExcTrap;
              FnTne:  if (a_q != b_q) r.exc = ExcTrap;
              default: r.exc = ExcReserved;
            endcase
          end
          OpJ, OpJal: begin
            r.redir  = 1'b1;
            r.target = {pc4[31:28], instr_q[25:0], 2'b00};
            if (op == OpJal) begin
              wb_req = 1'b1;
              wb_r   = LinkReg;
              wb_v   = pc4;
            end
          end
          OpBeq, OpBne, OpBlez, OpBgtz: begin
            r.target = pc4 + {simm[29:0], 2'b00};
            case (op)
              OpBeq:   r.redir = (a_q == b_q);
              OpBne:   r.redir = (a_q != b_q);
              OpBlez:  r.redir = (a_q == 32'd0) || a_q[31];
              default: r.redir = (a_q != 32'd0) && !a_q[31];
            endcase
            if (!r.redir) r.target = '0;
          end
          OpAddi: begin
            if (((a_q ^ sum) & (y ^ sum)) >> 31 != 32'd0) r.exc = ExcOverflow;
            else begin wb_req = 1'b1; wb_v = sum; end
          end
          OpAddiu: begin wb_req = 1'b1; wb_v = sum; end
          OpSlti:  begin wb_req = 1'b1; wb_v = {31'd0, lts}; end
          OpSltiu: begin wb_req = 1'b1; wb_v = {31'd0, ltu}; end
          OpAndi:  begin wb_req = 1'b1; wb_v = a_q & {16'd0, imm}; end
          OpOri:   begin wb_req = 1'b1; wb_v = a_q | {16'd0, imm}; end
          OpXori:  begin wb_req = 1'b1; wb_v = a_q ^ {16'd0, imm}; end
          OpLui:   begin wb_req = 1'b1; wb_v = {imm, 16'd0}; end
          OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr,
          OpSb, OpSh, OpSwl, OpSw, OpSwr: begin
            if (mem_fault) begin
              r.exc = is_store ? ExcStoreAddr : ExcLoadAddr;
              r.bad = addr;
            end else if (is_store) begin
              mem_we = 1'b1;
              case (op)
                OpSb: begin
                  mem_be = 4'b0001 << b2;
                  mem_wd = {4{b_q[7:0]}};
                end
                OpSh: begin
                  mem_be = b2[1] ? 4'b1100 : 4'b0011;
                  mem_wd = {2{b_q[15:0]}};
                end
                OpSwl: begin
                  mem_be = 4'b1111 >> 2'(2'd3 - b2);
                  mem_wd = b_q >> {2'(2'd3 - b2), 3'b000};
                end
                OpSwr: begin
                  mem_be = 4'b1111 << b2;
                  mem_wd = b_q << {b2, 3'b000};
                end
                default: begin
                  mem_be = 4'b1111;
                  mem_wd = b_q;
                end
              endcase
            end
          end
          default: r.exc = ExcReserved;
        endcase
      end
      StLoad: begin
        wb_req = 1'b1;
        case (op)
          OpLb:  wb_v = {{24{w[{b2, 3'b111}]}}, 8'(w >> {b2, 3'b000})};
          OpLbu: wb_v = {24'd0, 8'(w >> {b2, 3'b000})};
          OpLh:  wb_v = {{16{w[{b2[1], 4'b1111}]}}, 16'(w >> {b2, 3'b000})};
          OpLhu: wb_v = {16'd0, 16'(w >> {b2, 3'b000})};
          OpLwl: begin
            ld_mask = 32'hFFFFFFFF >> {3'({1'b0, b2} + 3'd1), 3'b000};
            wb_v    = (w << {2'(2'd3 - b2), 3'b000}) | (b_q & ld_mask);
          end
          OpLwr: begin
            ld_mask = 32'hFFFFFFFF << {3'(3'd4 - {1'b0, b2}), 3'b000};
            wb_v    = (w >> {b2, 3'b000}) | (b_q & ld_mask);
          end
          default: wb_v = w;
        endcase
      end
      StMd: begin
        if (md_rsp.done) begin
          hi_we = 1'b1;
          lo_we = 1'b1;
          hi_wd = md_rsp.hi;
          lo_wd = md_rsp.lo;
          res_d = '0;
        end
      end
      default: ;
    endcase
    if ((state_q == StExec) || (state_q == StLoad)) begin
      if (wb_req && (wb_r != 5'd0)) begin
        rf_we   = 1'b1;
        rf_wa   = wb_r;
        rf_wd   = wb_v;
        r.wbv   = 1'b1;
        r.wbr   = wb_r;
        r.wbval = wb_v;
      end
      res_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
      rf_vld_q  <= '0;
      ov_q      <= 1'b0;
      hi_q      <= '0;
      lo_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_cnt_q <= clr_cnt_q + Aw'(1);
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (out_load)         ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      if (hi_we) hi_q <= hi_wd;
      if (lo_we) lo_q <= lo_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) out_q <= res_q;
    if (in_acc) begin
      instr_q <= in_i.instr;
      pc_q    <= in_i.pc_read;
      a_q     <= rf_vld_q[rs_in] ? rf[rs_in] : 32'd0;
      b_q     <= rf_vld_q[rt_in] ? rf[rt_in] : 32'd0;
    end
    if (rf_we) rf[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int i = 0; i < 4; i++) begin
        if (mem_be[i]) mem[mem_wa][8*i +: 8] <= mem_wd[8*i +: 8];
      end
    end
    if (state_q == StExec) mem_rdata_q <= mem[addr[Aw+1:2]];
  end

  assign out_o.valid     = ov_q;
  assign out_o.exc_code  = out_q.exc;
  assign out_o.bad_vaddr = out_q.bad;
  assign out_o.redirect  = out_q.redir;
  assign out_o.target_pc = out_q.target;
  assign out_o.wb_valid  = out_q.wbv;
  assign out_o.wb_reg    = out_q.wbr;
  assign out_o.wb_value  = out_q.wbval;

  a_reg_zero_never_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_vld_q[0]) else $error("register zero marked written");

  a_md_done_in_md: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (state_q == StMd)) else $error("multiply/divide result outside its step");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_i.ready) else $error("transaction taken during clearing pass");

  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.cmd) |=> (state_q == StExec)) else $error("instruction not executed");

endmodule

### tb/tb_if_note.sv
// Testbench helper package: transaction types shared by the stimulus and the checker.
`timescale 1ns / 1ps
package rie_tb_pkg;

  typedef struct {
    logic        cmd;
    logic [31:0] instr;
    logic [31:0] pc_read;
    logic [13:0] mem_index;
    logic [31:0] mem_word;
  } op_txn_t;

  typedef struct {
    logic [2:0]  exc_code;
    logic [31:0] bad_vaddr;
    logic        redirect;
    logic [31:0] target_pc;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
  } res_txn_t;

endpackage

### tb/testbench.sv
// Testbench top: random and directed instruction streams checked against a behavioral predictor.
`timescale 1ns / 1ps
module testbench;
  import rie_pkg::*;
  import rie_tb_pkg::*;

  localparam int unsigned MemSize = 65536;
  localparam int unsigned WatchLimit = 100000;
  localparam int unsigned NumRandom = 1430;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rie_in_if in_ch();
  rie_out_if out_ch();

  risc_integer_execute_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  logic [31:0] gpr_model [32];
  logic [31:0] hi_model;
  logic [31:0] lo_model;
  logic [7:0]  mem_model [MemSize];

  res_txn_t    pending_res[$];
  int unsigned err_count = 0;
  int unsigned res_count = 0;
  int unsigned sent_count = 0;
  int unsigned idle_cycles = 0;
  bit          stim_done = 1'b0;
  bit          rand_ready = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("MISMATCH result %0d %s: got %h want %h", res_count, what, got, want);
  endtask

  task automatic check_fields(input string tag, input res_txn_t got, input res_txn_t want);
    if (got.exc_code != want.exc_code)
      report_mismatch({tag, " exc_code"}, 32'(got.exc_code), 32'(want.exc_code));
    if (got.bad_vaddr != want.bad_vaddr)
      report_mismatch({tag, " bad_vaddr"}, got.bad_vaddr, want.bad_vaddr);
    if (got.redirect != want.redirect)
      report_mismatch({tag, " redirect"}, 32'(got.redirect), 32'(want.redirect));
    if (got.target_pc != want.target_pc)
      report_mismatch({tag, " target_pc"}, got.target_pc, want.target_pc);
    if (got.wb_valid != want.wb_valid)
      report_mismatch({tag, " wb_valid"}, 32'(got.wb_valid), 32'(want.wb_valid));
    if (got.wb_reg != want.wb_reg)
      report_mismatch({tag, " wb_reg"}, 32'(got.wb_reg), 32'(want.wb_reg));
    if (got.wb_value != want.wb_value)
      report_mismatch({tag, " wb_value"}, got.wb_value, want.wb_value);
  endtask

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra_word(input logic [31:0] v, input logic [4:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic void write_reg(ref res_txn_t r, input logic [4:0] idx,
                                    input logic [31:0] val);
    if (idx == 5'd0) return;
    gpr_model[idx] = val;
    r.wb_valid = 1'b1;
    r.wb_reg   = idx;
    r.wb_value = val;
  endfunction

  function automatic void run_special(ref res_txn_t r, input logic [31:0] ins,
                                      input logic [31:0] pc);
    logic [4:0]  rs_f, rt_f, rd_f, sa;
    logic [31:0] a, b, v, q, m, ma, mb;
    logic [63:0] prod;
    rs_f = ins[25:21];
    rt_f = ins[20:16];
    rd_f = ins[15:11];
    sa   = ins[10:6];
    a = gpr_model[rs_f];
    b = gpr_model[rt_f];
    case (ins[5:0])
      FnSll:     write_reg(r, rd_f, b << sa);
      FnSrl:     write_reg(r, rd_f, b >> sa);
      FnSra:     write_reg(r, rd_f, sra_word(b, sa));
      FnSllv:    write_reg(r, rd_f, b << a[4:0]);
      FnSrlv:    write_reg(r, rd_f, b >> a[4:0]);
      FnSrav:    write_reg(r, rd_f, sra_word(b, a[4:0]));
      FnJr: begin
        r.redirect = 1'b1;
        r.target_pc = a;
      end
      FnJalr: begin
        r.redirect = 1'b1;
        r.target_pc = a;
        write_reg(r, rd_f, pc + 32'd4);
      end
      FnMovz:    if (b == 32'd0) write_reg(r, rd_f, a);
      FnMovn:    if (b != 32'd0) write_reg(r, rd_f, a);
      FnSyscall: r.exc_code = ExcSyscall;
      FnBreak:   r.exc_code = ExcBreak;
      FnMfhi:    write_reg(r, rd_f, hi_model);
      FnMthi:    hi_model = a;
      FnMflo:    write_reg(r, rd_f, lo_model);
      FnMtlo:    lo_model = a;
      FnMult: begin
        prod = $unsigned($signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}));
        lo_model = prod[31:0];
        hi_model = prod[63:32];
      end
      FnMultu: begin
        prod = {32'd0, a} * {32'd0, b};
        lo_model = prod[31:0];
        hi_model = prod[63:32];
      end
      FnDiv: begin
        if (b == 32'd0) begin
          lo_model = 32'hFFFF_FFFF;
          hi_model = a;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          m = ma % mb;
          lo_model = (a[31] != b[31]) ? -q : q;
          hi_model = a[31] ? -m : m;
        end
      end
      FnDivu: begin
        if (b == 32'd0) begin
          lo_model = 32'hFFFF_FFFF;
          hi_model = a;
        end else begin
          lo_model = a / b;
          hi_model = a % b;
        end
      end
      FnAdd: begin
        v = a + b;
        if (((a ^ v) & (b ^ v)) >> 31) r.exc_code = ExcOverflow;
        else write_reg(r, rd_f, v);
      end
      FnAddu:    write_reg(r, rd_f, a + b);
      FnSub: begin
        v = a - b;
        if (((a ^ b) & (a ^ v)) >> 31) r.exc_code = ExcOverflow;
        else write_reg(r, rd_f, v);
      end
      FnSubu:    write_reg(r, rd_f, a - b);
      FnAnd:     write_reg(r, rd_f, a & b);
      FnOr:      write_reg(r, rd_f, a | b);
      FnXor:     write_reg(r, rd_f, a ^ b);
      FnNor:     write_reg(r, rd_f, ~(a | b));
      FnSlt:     write_reg(r, rd_f, {31'd0, $signed(a) < $signed(b)});
      FnSltu:    write_reg(r, rd_f, {31'd0, a < b});
      FnTge:     if (!($signed(a) < $signed(b))) r.exc_code = ExcTrap;
      FnTgeu:    if (a >= b) r.exc_code = ExcTrap;
      FnTlt:     if ($signed(a) < $signed(b)) r.exc_code = ExcTrap;
      FnTltu:    if (a < b) r.exc_code = ExcTrap;
      FnTeq:     if (a == b) r.exc_code = ExcTrap;
      FnTne:     if (a != b) r.exc_code = ExcTrap;
      default:   r.exc_code = ExcReserved;
    endcase
  endfunction

  function automatic void run_mem(ref res_txn_t r, input logic [5:0] op,
                                  input logic [31:0] ins);
    logic [31:0] addr, t, v, keep, lo_a, hi_a;
    logic [1:0]  bo;
    logic [2:0]  code;
    addr = gpr_model[ins[25:21]] + sext16(ins[15:0]);
    t    = gpr_model[ins[20:16]];
    bo   = addr[1:0];
    v    = 32'd0;
    code = (op >= OpSb) ? ExcStoreAddr : ExcLoadAddr;
    lo_a = addr;
    hi_a = addr;
    if (op inside {OpLh, OpLhu, OpSh}) begin
      if (addr[0]) begin
        r.exc_code = code;
        r.bad_vaddr = addr;
        return;
      end
      hi_a = addr + 32'd1;
    end
    if (op inside {OpLw, OpSw}) begin
      if (bo != 2'd0) begin
        r.exc_code = code;
        r.bad_vaddr = addr;
        return;
      end
      hi_a = addr + 32'd3;
    end
    if (op inside {OpLwl, OpSwl}) lo_a = addr - bo;
    if (op inside {OpLwr, OpSwr}) hi_a = addr | 32'd3;
    if (lo_a >= MemSize || hi_a >= MemSize) begin
      r.exc_code = code;
      r.bad_vaddr = addr;
      return;
    end
    case (op)
      OpLb:  write_reg(r, ins[20:16], {{24{mem_model[addr][7]}}, mem_model[addr]});
      OpLbu: write_reg(r, ins[20:16], {24'd0, mem_model[addr]});
      OpLh:  write_reg(r, ins[20:16], sext16({mem_model[addr + 1], mem_model[addr]}));
      OpLhu: write_reg(r, ins[20:16], {16'd0, mem_model[addr + 1], mem_model[addr]});
      OpLw:  write_reg(r, ins[20:16], {mem_model[addr + 3], mem_model[addr + 2],
                                       mem_model[addr + 1], mem_model[addr]});
      OpLwl: begin
        for (int i = 0; i <= bo; i++) v |= 32'(mem_model[addr - i]) << (24 - 8 * i);
        keep = (bo == 2'd3) ? 32'd0 : (32'hFFFF_FFFF >> (8 * (bo + 1)));
        write_reg(r, ins[20:16], v | (t & keep));
      end
      OpLwr: begin
        for (int i = 0; i < 4 - bo; i++) v |= 32'(mem_model[addr + i]) << (8 * i);
        keep = (bo == 2'd0) ? 32'd0 : (32'hFFFF_FFFF << (8 * (4 - bo)));
        write_reg(r, ins[20:16], v | (t & keep));
      end
      OpSb:  mem_model[addr] = t[7:0];
      OpSh: begin
        mem_model[addr] = t[7:0];
        mem_model[addr + 1] = t[15:8];
      end
      OpSw:  for (int i = 0; i < 4; i++) mem_model[addr + i] = 8'(t >> (8 * i));
      OpSwl: for (int i = 0; i <= bo; i++) mem_model[addr - i] = 8'(t >> (24 - 8 * i));
      default: for (int i = 0; i < 4 - bo; i++) mem_model[addr + i] = 8'(t >> (8 * i));
    endcase
  endfunction

  function automatic res_txn_t predict_result(input op_txn_t tx);
    res_txn_t    r;
    logic [5:0]  op;
    logic [31:0] a, s, v, imm;
    logic [31:0] base;
    r = '{default: '0};
    op = tx.instr[31:26];
    if (tx.cmd) begin
      base = {16'd0, tx.mem_index, 2'b00};
      if (base + 32'd3 < MemSize)
        for (int i = 0; i < 4; i++) mem_model[base + i] = 8'(tx.mem_word >> (8 * i));
      return r;
    end
    a = gpr_model[tx.instr[25:21]];
    imm = {16'd0, tx.instr[15:0]};
    s = sext16(tx.instr[15:0]);
    case (op)
      OpSpecial: run_special(r, tx.instr, tx.pc_read);
      OpJ, OpJal: begin
        r.redirect = 1'b1;
        r.target_pc = ((tx.pc_read + 32'd4) & 32'hF000_0000) |
                      ((tx.instr << 2) & 32'h0FFF_FFFC);
        if (op == OpJal) write_reg(r, LinkReg, tx.pc_read + 32'd4);
      end
      OpBeq, OpBne, OpBlez, OpBgtz: begin
        if ((op == OpBeq && a == gpr_model[tx.instr[20:16]]) ||
            (op == OpBne && a != gpr_model[tx.instr[20:16]]) ||
            (op == OpBlez && (a == 32'd0 || a[31])) ||
            (op == OpBgtz && a != 32'd0 && !a[31])) begin
          r.redirect = 1'b1;
          r.target_pc = tx.pc_read + 32'd4 + (s << 2);
        end
      end
      OpAddi: begin
        v = a + s;
        if (((a ^ v) & (s ^ v)) >> 31) r.exc_code = ExcOverflow;
        else write_reg(r, tx.instr[20:16], v);
      end
      OpAddiu: write_reg(r, tx.instr[20:16], a + s);
      OpSlti:  write_reg(r, tx.instr[20:16], {31'd0, $signed(a) < $signed(s)});
      OpSltiu: write_reg(r, tx.instr[20:16], {31'd0, a < s});
      OpAndi:  write_reg(r, tx.instr[20:16], a & imm);
      OpOri:   write_reg(r, tx.instr[20:16], a | imm);
      OpXori:  write_reg(r, tx.instr[20:16], a ^ imm);
      OpLui:   write_reg(r, tx.instr[20:16], imm << 16);
      OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr, OpSb, OpSh, OpSwl, OpSw, OpSwr:
        run_mem(r, op, tx.instr);
      default: r.exc_code = ExcReserved;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs_f,
                                         input logic [4:0] rt_f, input logic [4:0] rd_f,
                                         input logic [4:0] sa);
    return {OpSpecial, rs_f, rt_f, rd_f, sa, fn};
  endfunction

  function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs_f,
                                         input logic [4:0] rt_f, input logic [15:0] imm);
    return {op, rs_f, rt_f, imm};
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0]  ops [27];
    logic [5:0]  fns [43];
    logic [31:0] w;
    int unsigned pick;
    ops = '{OpSpecial, OpJ, OpJal, OpBeq, OpBne, OpBlez, OpBgtz, OpAddi, OpAddiu, OpSlti,
            OpSltiu, OpAndi, OpOri, OpXori, OpLui, OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu,
            OpLwr, OpSb, OpSh, OpSwl, OpSw, OpSwr};
    fns = '{FnSll, FnSrl, FnSra, FnSllv, FnSrlv, FnSrav, FnJr, FnJalr, FnMovz, FnMovn,
            FnSyscall, FnBreak, FnMfhi, FnMthi, FnMflo, FnMtlo, FnMult, FnMultu, FnDiv,
            FnDivu, FnAdd, FnAddu, FnSub, FnSubu, FnAnd, FnOr, FnXor, FnNor, FnSlt, FnSltu,
            FnTge, FnTgeu, FnTlt, FnTltu, FnTeq, FnTne, FnAdd, FnAddu, FnSubu, FnOr, FnSlt,
            FnMflo, FnMfhi};
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4) return w;
    if (pick < 40) begin
      w[31:26] = OpSpecial;
      w[5:0] = fns[$urandom_range(0, 42)];
      return w;
    end
    w[31:26] = ops[$urandom_range(1, 26)];
    // keep most memory addresses inside the data memory: small base registers, small offsets
    if (w[31:26] >= OpLb && $urandom_range(0, 9) < 8) begin
      w[25:21] = 5'($urandom_range(0, 3));
      w[15:0] = 16'($urandom_range(0, 600));
    end
    return w;
  endfunction

  task automatic send_op(input op_txn_t tx, output res_txn_t pred);
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= tx.cmd;
    in_ch.instr     <= tx.instr;
    in_ch.pc_read   <= tx.pc_read;
    in_ch.mem_index <= tx.mem_index;
    in_ch.mem_word  <= tx.mem_word;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = predict_result(tx);
    pending_res.push_back(pred);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_checked(input op_txn_t tx, input bit has_want, input res_txn_t want);
    res_txn_t pred;
    send_op(tx, pred);
    if (has_want) check_fields($sformatf("table row %0d", sent_count), pred, want);
  endtask

  initial begin
    op_txn_t     tx;
    op_txn_t     rows[$];
    res_txn_t    wants[$];
    bit          known[$];
    res_txn_t    none_r;
    res_txn_t    w;
    res_txn_t    pred;
    for (int i = 0; i < 32; i++) gpr_model[i] = 32'd0;
    hi_model = 32'd0;
    lo_model = 32'd0;
    for (int i = 0; i < MemSize; i++) mem_model[i] = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.instr = 32'd0;
    in_ch.pc_read = 32'd0;
    in_ch.mem_index = 14'd0;
    in_ch.mem_word = 32'd0;
    out_ch.ready = 1'b0;
    none_r = '{default: '0};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: instr, pc, preload fields; expected result where obvious
    rows.push_back('{1'b1, 32'd0, 32'd0, 14'd0, 32'h8000_00FF});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF, 32'hFFFF_FFFF});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpLui, 5'd0, 5'd1, 16'h7FFF), 32'd0, 14'd0, 32'd0});
    w = none_r; w.wb_valid = 1; w.wb_reg = 5'd1; w.wb_value = 32'h7FFF_0000;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpOri, 5'd1, 5'd1, 16'hFFFF), 32'd0, 14'd0, 32'd0});
    w.wb_value = 32'h7FFF_FFFF;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpAddi, 5'd1, 5'd2, 16'h0001), 32'd0, 14'd0, 32'd0});
    w = none_r; w.exc_code = ExcOverflow;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnAdd, 5'd1, 5'd1, 5'd3, 5'd0), 32'd0, 14'd0, 32'd0});
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpLui, 5'd0, 5'd0, 16'hFFFF), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpLui, 5'd0, 5'd4, 16'h8000), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b0);
    rows.push_back('{1'b0, i_word(OpAddiu, 5'd0, 5'd5, 16'hFFFF), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b0);
    rows.push_back('{1'b0, r_word(FnSub, 5'd4, 5'd1, 5'd6, 5'd0), 32'd0, 14'd0, 32'd0});
    w = none_r; w.exc_code = ExcOverflow;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnDiv, 5'd4, 5'd5, 5'd0, 5'd0), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnMflo, 5'd0, 5'd0, 5'd7, 5'd0), 32'd0, 14'd0, 32'd0});
    w = none_r; w.wb_valid = 1; w.wb_reg = 5'd7; w.wb_value = 32'h8000_0000;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnDivu, 5'd1, 5'd0, 5'd0, 5'd0), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnMfhi, 5'd0, 5'd0, 5'd8, 5'd0), 32'd0, 14'd0, 32'd0});
    w.wb_reg = 5'd8; w.wb_value = 32'h7FFF_FFFF;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnMult, 5'd4, 5'd5, 5'd0, 5'd0), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpLw, 5'd0, 5'd9, 16'h0002), 32'd0, 14'd0, 32'd0});
    w = none_r; w.exc_code = ExcLoadAddr; w.bad_vaddr = 32'd2;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpSwr, 5'd0, 5'd1, 16'hFFFF), 32'd0, 14'd0, 32'd0});
    w = none_r; w.exc_code = ExcStoreAddr; w.bad_vaddr = 32'hFFFF_FFFF;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpLwl, 5'd0, 5'd10, 16'h0003), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b0);
    rows.push_back('{1'b0, i_word(OpLwr, 5'd0, 5'd11, 16'h0001), 32'd0, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b0);
    rows.push_back('{1'b0, i_word(OpBgtz, 5'd0, 5'd0, 16'h0010), 32'h100, 14'd0, 32'd0});
    wants.push_back(none_r); known.push_back(1'b1);
    rows.push_back('{1'b0, i_word(OpBlez, 5'd0, 5'd7, 16'h8000), 32'h0002_0000, 14'd0, 32'd0});
    w = none_r; w.redirect = 1; w.target_pc = 32'h0000_0004;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnJalr, 5'd1, 5'd0, 5'd31, 5'd0), 32'hFFFF_FFFC, 14'd0, 32'd0});
    w = none_r; w.redirect = 1; w.target_pc = 32'h7FFF_FFFF;
    w.wb_valid = 1; w.wb_reg = 5'd31; w.wb_value = 32'd0;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, {OpJal, 26'h3FF_FFFF}, 32'hEFFF_FFFC, 14'd0, 32'd0});
    w.target_pc = 32'hFFFF_FFFC; w.wb_value = 32'hF000_0000;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnBreak, 5'd0, 5'd0, 5'd0, 5'd0), 32'd0, 14'd0, 32'd0});
    w = none_r; w.exc_code = ExcBreak;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, r_word(FnTeq, 5'd0, 5'd0, 5'd0, 5'd0), 32'd0, 14'd0, 32'd0});
    w.exc_code = ExcTrap;
    wants.push_back(w); known.push_back(1'b1);
    rows.push_back('{1'b0, {6'h01, 26'h0}, 32'd0, 14'd0, 32'd0});
    w.exc_code = ExcReserved;
    wants.push_back(w); known.push_back(1'b1);

    foreach (rows[i]) send_checked(rows[i], known[i], wants[i]);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
        while (pending_res.size() != 0) @(negedge clk_i);
      end
      tx.cmd = ($urandom_range(0, 9) == 0);
      tx.instr = rand_instr();
      tx.pc_read = $urandom;
      tx.mem_index = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 160));
      tx.mem_word = $urandom;
      send_op(tx, pred);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      rand_ready = 1'b0;
      out_ch.ready <= 1'b0;
    end else if (!rand_ready) begin
      rand_ready = ($urandom_range(0, 7) == 0);
      out_ch.ready <= rand_ready;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    res_txn_t want;
    res_txn_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd1, 32'd0);
      end else begin
        want = pending_res.pop_front();
        got.exc_code  = out_ch.exc_code;
        got.bad_vaddr = out_ch.bad_vaddr;
        got.redirect  = out_ch.redirect;
        got.target_pc = out_ch.target_pc;
        got.wb_valid  = out_ch.wb_valid;
        got.wb_reg    = out_ch.wb_reg;
        got.wb_value  = out_ch.wb_value;
        check_fields("output", got, want);
      end
      res_count++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Watchdog expired after %0d sent, %0d results", sent_count, res_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d instruction and preload transactions, %0d results checked,", sent_count,
             res_count);
    $display("covering ALU, mult/div, branches, jumps, traps and partial-word memory access.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
